@@ sv/swm_pkg.sv @@
package swm_pkg;

    localparam int WINDOW_MAX = 16;
    localparam int SAMPLE_W   = 16;
    localparam int WSIZE_W    = 5;
    localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W      = IDX_W;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int WSIZE_RST  = 5;

    // register index of window_size
    localparam logic [ADDR_W-3:0] REG_WSIZE = '0;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // what a cell shows its neighbors
    typedef struct packed {
        t_sample              val;
        logic [AGE_W-1:0]     age;
        logic                 gt;       // invalid or greater than the new sample
        logic                 delseen;  // the oldest sits here or below
    } t_cell_link;

    // common controls for every cell of the chain
    typedef struct packed {
        logic                 adv;
        t_sample              x;
        logic                 full;
        logic [AGE_W-1:0]     oldest;
        logic [CNT_W-1:0]     cnt;
    } t_cell_ctrl;

endpackage

@@ sv/swm_sample_if.sv @@
interface swm_sample_if;
    import swm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ sv/swm_median_if.sv @@
interface swm_median_if;
    import swm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

@@ sv/swm_cell.sv @@
module swm_cell (
    input  logic                      i_clk,
    input  swm_pkg::t_cell_ctrl       i_ctrl,
    input  logic [swm_pkg::IDX_W-1:0] i_idx,
    input  swm_pkg::t_cell_link       i_left,
    input  swm_pkg::t_cell_link       i_right,
    output swm_pkg::t_cell_link       o_link
);
    import swm_pkg::*;

    t_sample          r_val, n_val;
    logic [AGE_W-1:0] r_age, n_age;

    logic             w_valid;
    logic             w_del;
    logic             w_delseen;
    logic             w_gt;
    t_sample          w_rem_val,  w_lrem_val;
    logic [AGE_W-1:0] w_rem_age,  w_lrem_age;
    logic             w_rem_gt,   w_lrem_gt;

    // local status of the held word
    assign w_valid   = CNT_W'(i_idx) < i_ctrl.cnt;
    assign w_gt      = !w_valid || (r_val > i_ctrl.x);
    assign w_del     = i_ctrl.full && w_valid && (r_age == i_ctrl.oldest);
    assign w_delseen = i_left.delseen || w_del;

    assign o_link = '{val: r_val, age: r_age, gt: w_gt, delseen: w_delseen};

    // word at this place once the oldest is dropped
    assign w_rem_val = w_delseen ? i_right.val : r_val;
    assign w_rem_age = w_delseen ? i_right.age : r_age;
    assign w_rem_gt  = w_delseen ? i_right.gt  : w_gt;

    // word at the left place once the oldest is dropped
    assign w_lrem_val = i_left.delseen ? r_val : i_left.val;
    assign w_lrem_age = i_left.delseen ? r_age : i_left.age;
    assign w_lrem_gt  = i_left.delseen ? w_gt  : i_left.gt;

    // keep, shift right, or take the new sample
    always_comb begin
        if (!w_rem_gt) begin
            n_val = w_rem_val;
            n_age = w_rem_age + 1'b1;
        end else if (w_lrem_gt) begin
            n_val = w_lrem_val;
            n_age = w_lrem_age + 1'b1;
        end else begin
            n_val = i_ctrl.x;
            n_age = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_val <= n_val;
            r_age <= n_age;
        end
    end

endmodule

@@ sv/sliding_window_median_core.sv @@
// Sliding-window median filter. Each accepted sample word enters a sorted row of
// WINDOW_MAX cells: the oldest sample leaves and the new one drops into
// its sorted place, every cell choosing between its own word, a neighbor's word and
// the new sample. The cells and a pending flag are registered when a sample is taken;
// the median is registered from the cells once the result side is free. One sample
// per cycle is sustained while the result side keeps up; a stalled result holds one
// further sample back. Writing window_size (offset 0) empties the window; sizes 0 and
// above WINDOW_MAX act as 1 and WINDOW_MAX. No clearing pass is needed after reset.
module sliding_window_median_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    swm_sample_if.sink                  i_smp,
    swm_median_if.source                o_med,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swm_pkg::ADDR_W-1:0]  paddr,
    input  logic [swm_pkg::DATA_W-1:0]  pwdata,
    output logic [swm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import swm_pkg::*;

    logic [WSIZE_W-1:0] r_wsize, n_wsize;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic               r_pend,  n_pend;
    logic               r_ov,    n_ov;
    t_sample            r_med,   n_med;

    logic               w_cfg_wr;
    logic               w_reg_hit;
    logic               w_acc;
    logic               w_out_free;
    logic               w_move;
    logic [CNT_W-1:0]   w_neff;
    logic               w_full;
    t_cell_ctrl         w_ctrl;
    t_cell_link         w_link [WINDOW_MAX];
    logic [IDX_W-1:0]   w_lo, w_hi;
    t_sample            w_vlo, w_vhi;
    logic [SAMPLE_W:0]  w_sum;
    logic [WINDOW_MAX-1:0] w_old;

    // config port
    assign pready    = 1'b1;
    assign w_reg_hit = paddr[ADDR_W-1:2] == REG_WSIZE;
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_reg_hit;
    assign prdata    = w_reg_hit ? DATA_W'(r_wsize) : '0;

    // handshakes
    assign w_out_free  = !r_ov || o_med.ready;
    assign w_move      = r_pend && w_out_free;
    assign i_smp.ready = !r_pend || w_out_free;
    assign w_acc       = i_smp.valid && i_smp.ready;
    assign o_med.valid  = r_ov;
    assign o_med.median = r_med;

    // clamp the window size
    always_comb begin
        if (r_wsize == '0) begin
            w_neff = CNT_W'(1);
        end else if (32'(r_wsize) > WINDOW_MAX) begin
            w_neff = CNT_W'(WINDOW_MAX);
        end else begin
            w_neff = CNT_W'(r_wsize);
        end
    end
    assign w_full = r_cnt == w_neff;

    assign w_ctrl = '{adv: w_acc, x: i_smp.sample, full: w_full,
                      oldest: AGE_W'(w_neff - 1'b1), cnt: r_cnt};

    // sorted row of cells
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        t_cell_link w_l, w_r;
        if (g == 0) begin : g_first
            assign w_l = '{val: '0, age: '0, gt: 1'b0, delseen: 1'b0};
        end else begin : g_mid_l
            assign w_l = w_link[g-1];
        end
        if (g == WINDOW_MAX - 1) begin : g_last
            assign w_r = '{val: '0, age: '0, gt: 1'b1, delseen: 1'b1};
        end else begin : g_mid_r
            assign w_r = w_link[g+1];
        end
        swm_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_idx  (IDX_W'(g)),
            .i_left (w_l),
            .i_right(w_r),
            .o_link (w_link[g])
        );
    end

    // pick the two middle words
    assign w_lo = IDX_W'((r_cnt - 1'b1) >> 1);
    assign w_hi = IDX_W'(r_cnt >> 1);
    always_comb begin
        w_vlo = '0;
        w_vhi = '0;
        w_old = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (IDX_W'(i) == w_lo) w_vlo = w_vlo | w_link[i].val;
            if (IDX_W'(i) == w_hi) w_vhi = w_vhi | w_link[i].val;
            w_old[i] = (CNT_W'(i) < r_cnt) && (CNT_W'(w_link[i].age) == r_cnt - 1'b1);
        end
    end
    assign w_sum = {w_vlo[SAMPLE_W-1], w_vlo} + {w_vhi[SAMPLE_W-1], w_vhi};

    // next state
    always_comb begin
        n_wsize = r_wsize;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        n_ov    = r_ov;
        n_med   = r_med;
        if (w_cfg_wr) begin
            n_wsize = pwdata[WSIZE_W-1:0];
            n_cnt   = '0;
        end else if (w_acc && !w_full) begin
            n_cnt = r_cnt + 1'b1;
        end
        if (w_move) begin
            n_med = t_sample'(w_sum[SAMPLE_W:1]);
            n_ov  = 1'b1;
        end else if (o_med.ready) begin
            n_ov  = 1'b0;
        end
        if (w_acc) begin
            n_pend = 1'b1;
        end else if (w_move) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= WSIZE_W'(WSIZE_RST);
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_wsize <= n_wsize;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
        r_med <= n_med;
    end

    // a window size write empties the window
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> r_cnt == '0)
        else $error("window not emptied after size write");

    // fill never passes the clamped size
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= w_neff)
        else $error("fill count above window size");

    // exactly one held word is the oldest
    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> $onehot(w_old))
        else $error("cell ages not a permutation");

    // an accepted word leaves a median pending
    a_acc_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_pend)
        else $error("accepted word lost");

endmodule

@@ bench/tb_sliding_window_median_core.sv @@
module tb_sliding_window_median_core;
    import swm_pkg::*;

    localparam int HOLD_LEN   = 120;
    localparam int IDLE_LIMIT = 3000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    swm_sample_if smp_if ();
    swm_median_if med_if ();

    sliding_window_median_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_med   (med_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // filter state mirrored on the bench side
    t_sample win_q[WINDOW_MAX];
    int      held      = 0;
    int      wsize_reg = WSIZE_RST;

    t_sample sample_q[$];
    t_sample median_q[$];
    int      samples_queued = 0;
    int      samples_taken  = 0;
    int      medians_seen   = 0;
    int      mismatches     = 0;
    int      idle_cycles    = 0;
    bit      steady         = 1'b0;

    int      send_gap     = 0;
    int      stall_left   = 0;
    int      hold_left    = 0;
    int      next_hold_at = 150;
    t_sample expected_med;

    // shift the word into the window and return the median of what is held
    function automatic t_sample push_sample_median(input t_sample x);
        t_sample srt[WINDOW_MAX];
        t_sample v;
        int      n, i, j, sum;
        n = (wsize_reg < 1) ? 1 : (wsize_reg > WINDOW_MAX) ? WINDOW_MAX : wsize_reg;
        if (held > n) held = n;
        if (held < n) begin
            win_q[held] = x;
            held++;
        end else begin
            for (i = 1; i < n; i++) win_q[i-1] = win_q[i];
            win_q[n-1] = x;
        end
        for (i = 0; i < held; i++) begin
            v = win_q[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        if (held % 2 == 1) return srt[held/2];
        // floor of the mean of the two middle words
        sum = int'(srt[held/2-1]) + int'(srt[held/2]);
        return t_sample'(sum >>> 1);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // full range, a narrow band with many ties, or the corners
    function automatic t_sample draw_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return t_sample'($urandom);
        if (r < 8) return t_sample'($urandom_range(0, 6) - 3);
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh8001;
            3: return 16'sh7FFE;
            4: return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // sample driver: offer the next pending word, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid  <= 1'b0;
            smp_if.sample <= '0;
        end else begin
            if (smp_if.valid && smp_if.ready) begin
                median_q = {median_q, push_sample_median(smp_if.sample)};
                samples_taken++;
            end
            if (!smp_if.valid || smp_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    smp_if.valid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    smp_if.valid  <= 1'b1;
                    smp_if.sample <= sample_q.pop_front();
                    send_gap = pick_gap();
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // median monitor: check each word, stall at random, now and then hold off for long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            med_if.ready <= 1'b0;
        end else begin
            if (med_if.valid && med_if.ready) begin
                medians_seen++;
                if (median_q.size() == 0) begin
                    $display("%0t: median %0d arrived with none expected", $time, med_if.median);
                    mismatches++;
                end else begin
                    expected_med = median_q.pop_front();
                    if (expected_med !== med_if.median) begin
                        $display("%0t: median mismatch: expected %0d, got %0d",
                                 $time, expected_med, med_if.median);
                        mismatches++;
                    end
                end
            end
            if (hold_left == 0 && medians_seen >= next_hold_at) begin
                hold_left = HOLD_LEN;
                next_hold_at += 270;
            end
            if (hold_left > 0) begin
                hold_left--;
                med_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                med_if.ready <= 1'b0;
            end else begin
                med_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // watchdog: count cycles with work pending and nothing moving
    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (med_if.valid && med_if.ready)
            || (samples_taken == samples_queued && median_q.size() == 0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic queue_sample(input t_sample x);
        sample_q = {sample_q, x};
        samples_queued++;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) queue_sample(draw_sample());
    endtask

    // wait until every word is taken and every median is back
    task automatic wait_drained();
        while (samples_taken != samples_queued || median_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup, access; upper data bits carry noise
    task automatic reg_write(input int idx, input logic [4:0] wsize);
        logic [DATA_W-1:0] data;
        data = $urandom;
        data[4:0] = wsize;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == int'(REG_WSIZE)) begin
            wsize_reg = int'(wsize);
            held = 0;
        end
    endtask

    task automatic random_phase(input int idx, input logic [4:0] wsize,
                                input int count, input bit no_idle);
        reg_write(idx, wsize);
        steady = no_idle;
        queue_random(count);
        wait_drained();
    endtask

    initial begin
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        med_if.ready  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size of five: fill, then shift out the oldest, extremes throughout
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(16'sh0000);
        queue_sample(16'shFFFF);
        queue_sample(16'sh0001);
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        wait_drained();

        // size zero acts as a window of one
        reg_write(int'(REG_WSIZE), 5'd0);
        queue_sample(16'sd100);
        queue_sample(-16'sd100);
        wait_drained();

        // write to an unmapped register: ignored, window kept
        reg_write(int'(REG_WSIZE) + 1, 5'd3);
        queue_sample(16'sd7);
        wait_drained();

        // even count rounding toward minus infinity
        reg_write(int'(REG_WSIZE), 5'd2);
        queue_sample(16'sh8000);
        queue_sample(16'sh8001);
        queue_sample(-16'sd3);
        queue_sample(16'sd4);
        wait_drained();

        // size above the maximum acts as the maximum
        reg_write(int'(REG_WSIZE), 5'd31);
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(16'sh7FFE);
        queue_sample(16'sh8001);
        wait_drained();

        // random words over a spread of window sizes
        random_phase(int'(REG_WSIZE), 5'd16, 70, 1'b0);
        random_phase(int'(REG_WSIZE), 5'd1, 40, 1'b0);
        random_phase(int'(REG_WSIZE), 5'd16, 60, 1'b1);
        random_phase(int'(REG_WSIZE), 5'd0, 30, 1'b0);
        random_phase(int'(REG_WSIZE), 5'd2, 40, 1'b0);
        random_phase(int'(REG_WSIZE), 5'd3, 40, 1'b0);
        random_phase(int'(REG_WSIZE) + 1, 5'd9, 20, 1'b0);
        random_phase(int'(REG_WSIZE), 5'd8, 50, 1'b1);
        random_phase(int'(REG_WSIZE), 5'd17, 50, 1'b0);
        for (int k = 0; k < 5; k++) begin
            random_phase(int'(REG_WSIZE), 5'($urandom_range(0, 31)),
                         $urandom_range(20, 50), k[0]);
        end
        random_phase(int'(REG_WSIZE), 5'd15, 40, 1'b0);
        random_phase(int'(REG_WSIZE), 5'd5, 40, 1'b0);

        repeat (10) @(posedge i_clk);
        if (median_q.size() != 0) begin
            $display("%0t: %0d medians never arrived", $time, median_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
